FILE: src/fm_index_backward_search_top_defines.svh
// ----------------------------------------------------------------------------
// FM-index backward search: assertion macros
// Shared property wrappers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FM_INDEX_BACKWARD_SEARCH_TOP_DEFINES_SVH
`define FM_INDEX_BACKWARD_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define FMBS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define FMBS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FMBS_ASSERT_IMP(label, ante, cons, msg)
`define FMBS_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

FILE: src/fmbs_pkg.sv
// ----------------------------------------------------------------------------
// FM-index backward search: package
// Sizes, item types, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package fmbs_pkg;

   localparam int TEXT_LEN = 512;
   localparam int ALPHABET = 256;

   localparam int BOUND_W  = 10;
   localparam int KIND_W   = 2;
   localparam int SYMBOL_W = 8;
   localparam int ROWF_W   = 9;

   localparam int SYM_W  = $clog2(ALPHABET);
   localparam int ROW_W  = $clog2(TEXT_LEN);
   localparam int OCC_AW = ROW_W + SYM_W;
   localparam int IDX_W  = SYM_W + 1;

   localparam logic [KIND_W-1:0] KIND_START = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OCC   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [SYMBOL_W-1:0] symbol;
      logic [ROWF_W-1:0]   row;
      logic [BOUND_W-1:0]  value;
      logic                first;
      logic                last;
   } fmbs_req_type;

   typedef struct packed {
      logic [BOUND_W-1:0] low_bound;
      logic [BOUND_W-1:0] high_bound;
      logic               empty_res;
   } fmbs_rsp_type;

   typedef struct packed {
      logic               en;
      logic [SYM_W-1:0]   addr;
      logic [BOUND_W-1:0] data;
   } fmbs_start_wr_type;

   typedef struct packed {
      logic               en;
      logic [OCC_AW-1:0]  addr;
      logic [BOUND_W-1:0] data;
   } fmbs_occ_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST_LO,
      ST_SCAN,
      ST_REF_LO,
      ST_REF_HI,
      ST_CHECK,
      ST_EMIT
   } fmbs_state_type;

   // Saturate an add result to the bound width.
   function automatic logic [BOUND_W-1:0] sat_bound(input logic [BOUND_W:0] v);
      return v[BOUND_W] ? {BOUND_W{1'b1}} : v[BOUND_W-1:0];
   endfunction

   // Occurrence row for a rank: bound minus one, clamped to the last row.
   function automatic logic [ROW_W-1:0] rank_row(input logic [BOUND_W-1:0] b);
      logic [BOUND_W-1:0] r;
      r = b - BOUND_W'(1);
      if (32'(r) >= TEXT_LEN) begin
         return ROW_W'(TEXT_LEN - 1);
      end
      return ROW_W'(r);
   endfunction

   function automatic logic sym_ok(input logic [SYMBOL_W-1:0] s);
      return 32'(s) < ALPHABET;
   endfunction

   function automatic logic row_ok(input logic [ROWF_W-1:0] r);
      return 32'(r) < TEXT_LEN;
   endfunction

endpackage

FILE: src/fm_index_backward_search_top.sv
// ----------------------------------------------------------------------------
// FM-index backward search: top level
// Table storage, text length register and the search sequencer.
// ----------------------------------------------------------------------------
// Backward search over a loaded FM index. Load items (kind start or kind occ)
// write one entry of the start table or the occurrence table. Query items
// arrive last character first; the item marked first opens the interval,
// later items narrow it by rank, and the item marked last emits low_bound,
// high_bound and empty_res through an output register. A refining symbol is
// accepted with start and low-rank reads, then forms the low sum, the high sum
// and the empty check, in an order set by the single occurrence RAM read port
// and the one shared saturating adder. A first symbol is accepted with a start
// read, takes its low bound and, unless that is text_length - 1, walks the
// start table one entry per cycle over the symbols above it to tighten high;
// the empty check follows. Items that emit then load the output register from
// the emit state, and wait there while the previous result is still stalled.
// Query symbols outside the alphabet, and symbols that follow an empty
// interval, finish when accepted. The input is stalled while a query item is
// at work. The table RAMs are not cleared: reading an entry never written
// gives an unspecified value. text_length resets to 1 and is written through
// the csr_ port, which is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module fm_index_backward_search_top
   import fmbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fmbs_req_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fmbs_rsp_type       rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [BOUND_W-1:0] csr_wdata
);

   logic [BOUND_W-1:0] text_length_ff, text_length_in;

   fmbs_start_wr_type  start_wr;
   logic [SYM_W-1:0]   start_rd_addr;
   logic [BOUND_W-1:0] start_rd_data;
   fmbs_occ_wr_type    occ_wr;
   logic [OCC_AW-1:0]  occ_rd_addr;
   logic [BOUND_W-1:0] occ_rd_data;

   // Text length register: always ready, take the write data as is.
   assign csr_ready      = 1'b1;
   assign text_length_in = (csr_valid && csr_ready) ? csr_wdata : text_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_length_ff <= BOUND_W'(1);
      end else begin
         text_length_ff <= text_length_in;
      end
   end

   // Start table: one entry per symbol, read by the scan and by refinement.
   fmbs_ram #(
      .ADDR_W (SYM_W),
      .DATA_W (BOUND_W)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (start_wr.en),
      .wr_addr (start_wr.addr),
      .wr_data (start_wr.data),
      .rd_addr (start_rd_addr),
      .rd_data (start_rd_data)
   );

   // Occurrence table: addressed by {row, symbol}; one rank read per cycle.
   fmbs_ram #(
      .ADDR_W (OCC_AW),
      .DATA_W (BOUND_W)
   ) u_occ_ram (
      .clock   (clock),
      .wr_en   (occ_wr.en),
      .wr_addr (occ_wr.addr),
      .wr_data (occ_wr.data),
      .rd_addr (occ_rd_addr),
      .rd_data (occ_rd_data)
   );

   // Sequencer: handshakes, interval registers, shared adder, output register.
   fmbs_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .text_length   (text_length_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .start_wr      (start_wr),
      .start_rd_addr (start_rd_addr),
      .start_rd_data (start_rd_data),
      .occ_wr        (occ_wr),
      .occ_rd_addr   (occ_rd_addr),
      .occ_rd_data   (occ_rd_data)
   );

endmodule

FILE: src/fmbs_ram.sv
// ----------------------------------------------------------------------------
// FM-index backward search: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fmbs_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/fmbs_seq.sv
// ----------------------------------------------------------------------------
// FM-index backward search: sequencer
// Runs table loads, the start-table scan and rank refinement on one adder.
// ----------------------------------------------------------------------------
`include "fm_index_backward_search_top_defines.svh"

module fmbs_seq
   import fmbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [BOUND_W-1:0] text_length,
   input  logic               req_valid,
   output logic               req_stall,
   input  fmbs_req_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fmbs_rsp_type       rsp_data,
   output fmbs_start_wr_type  start_wr,
   output logic [SYM_W-1:0]   start_rd_addr,
   input  logic [BOUND_W-1:0] start_rd_data,
   output fmbs_occ_wr_type    occ_wr,
   output logic [OCC_AW-1:0]  occ_rd_addr,
   input  logic [BOUND_W-1:0] occ_rd_data
);

   localparam logic [IDX_W-1:0] ALPHA_END = IDX_W'(ALPHABET);

   fmbs_state_type state_ff, state_in;

   logic [BOUND_W-1:0]  low_ff, low_in;
   logic [BOUND_W-1:0]  high_ff, high_in;
   logic                empty_ff, empty_in;
   logic [SYMBOL_W-1:0] sym_ff, sym_in;
   logic                last_ff, last_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   fmbs_rsp_type        rsp_data_ff, rsp_data_in;

   logic [BOUND_W-1:0]  add_a, add_b;
   logic [BOUND_W:0]    add_sum;
   logic [IDX_W-1:0]    idx_next;
   logic                slot_free;
   logic                req_acc;
   fmbs_state_type      fin_state;

   // Shared adder
   assign add_sum = {1'b0, add_a} + {1'b0, add_b};

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign fin_state = req_data.last ? ST_EMIT : ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_ff       <= '0;
         high_ff      <= '0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      empty_in      = empty_ff;
      sym_in        = sym_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      start_wr      = '0;
      occ_wr        = '0;
      start_rd_addr = SYM_W'(sym_ff);
      occ_rd_addr   = {rank_row(high_ff), SYM_W'(sym_ff)};
      add_a         = start_rd_data;
      add_b         = occ_rd_data;
      idx_next      = idx_ff + IDX_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_data.kind)
                  KIND_START: begin
                     start_wr.en   = sym_ok(req_data.symbol);
                     start_wr.addr = SYM_W'(req_data.symbol);
                     start_wr.data = req_data.value;
                  end
                  KIND_OCC: begin
                     occ_wr.en   = sym_ok(req_data.symbol) && row_ok(req_data.row);
                     occ_wr.addr = {ROW_W'(req_data.row), SYM_W'(req_data.symbol)};
                     occ_wr.data = req_data.value;
                  end
                  KIND_QUERY: begin
                     sym_in        = req_data.symbol;
                     last_in       = req_data.last;
                     start_rd_addr = SYM_W'(req_data.symbol);
                     occ_rd_addr   = {rank_row(low_ff), SYM_W'(req_data.symbol)};
                     if (req_data.first) begin
                        empty_in = 1'b0;
                        if (!sym_ok(req_data.symbol)) begin
                           empty_in = 1'b1;
                           state_in = fin_state;
                        end else begin
                           state_in = ST_FIRST_LO;
                        end
                     end else if (empty_ff) begin
                        state_in = fin_state;
                     end else if (!sym_ok(req_data.symbol)) begin
                        empty_in = 1'b1;
                        state_in = fin_state;
                     end else begin
                        state_in = ST_REF_LO;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIRST_LO: begin
            low_in   = start_rd_data;
            idx_next = IDX_W'(sym_ff) + IDX_W'(1);
            if (text_length != '0 && start_rd_data == text_length - BOUND_W'(1)) begin
               add_b    = BOUND_W'(1);
               high_in  = sat_bound(add_sum);
               state_in = ST_CHECK;
            end else begin
               high_in = text_length;
               if (idx_next < ALPHA_END) begin
                  start_rd_addr = idx_next[SYM_W-1:0];
                  idx_in        = idx_next;
                  state_in      = ST_SCAN;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_SCAN: begin
            // Tighten high to the smallest start above low.
            if (start_rd_data > low_ff && start_rd_data < high_ff) begin
               high_in = start_rd_data;
            end
            if (idx_next < ALPHA_END) begin
               start_rd_addr = idx_next[SYM_W-1:0];
               idx_in        = idx_next;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_REF_LO: begin
            add_b    = (low_ff == '0) ? '0 : occ_rd_data;
            low_in   = sat_bound(add_sum);
            state_in = ST_REF_HI;
         end
         ST_REF_HI: begin
            add_b    = (high_ff == '0) ? '0 : occ_rd_data;
            high_in  = sat_bound(add_sum);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (low_ff >= high_ff) begin
               empty_in = 1'b1;
            end
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.low_bound  = low_ff;
               rsp_data_in.high_bound = high_ff;
               rsp_data_in.empty_res  = empty_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FMBS_ASSERT_NXT(a_scan_ends, (state_ff == ST_SCAN) && (idx_ff + IDX_W'(1) >= ALPHA_END), state_ff == ST_CHECK, "scan did not end at the last symbol")
   `FMBS_ASSERT_NXT(a_scan_narrows, state_ff == ST_SCAN, high_ff <= $past(high_ff), "scan widened the upper bound")
   `FMBS_ASSERT_NXT(a_check_flags, (state_ff == ST_CHECK) && (low_ff >= high_ff), empty_ff, "empty interval not flagged")
   `FMBS_ASSERT_NXT(a_frozen, req_acc && (req_data.kind == KIND_QUERY) && !req_data.first && empty_ff, $stable(low_ff) && $stable(high_ff) && empty_ff, "frozen interval changed")
   `FMBS_ASSERT_NXT(a_emit_loads, (state_ff == ST_EMIT) && slot_free, rsp_valid_ff && (state_ff == ST_IDLE), "result not loaded from emit")

endmodule
